// ===== sv/itaf_pkg.sv =====
// Shared constants, types and the digit character function for the integer formatter.
package itaf_pkg;

    localparam int MAX_FIELD  = 60;
    localparam int NUM_DIGITS = 22;
    localparam int DIG_IDX_W  = 5;
    localparam int CNT_W      = 6;
    localparam int DD_STEPS   = 32;
    localparam int DD_CNT_W   = 6;

    // radix codes on the mode field
    localparam logic [1:0] MODE_DEC = 2'd0;
    localparam logic [1:0] MODE_OCT = 2'd1;
    localparam logic [1:0] MODE_HEX = 2'd2;

    // ASCII characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_PLAN,
        ST_EMIT
    } state_t;

    // character position boundaries of each output section
    typedef struct packed {
        logic [CNT_W-1:0] b_pre;
        logic [CNT_W-1:0] b_sgn;
        logic [CNT_W-1:0] b_lpad;
        logic [CNT_W-1:0] b_zero;
        logic [CNT_W-1:0] b_dig;
        logic [CNT_W-1:0] total;
        logic [7:0]       sign_sym;
        logic             upper;
    } plan_t;

    // map one digit value to its ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

// ===== sv/integer_to_ascii_formatter.sv =====
// Top level of the integer formatter: sequencer, section plan and unit hookup.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | value, signed_value, mode, flags, widths
//  out     | out_valid / out_ready| out_char, last (one transfer per character)
//
// Hex and octal items are split into digits on load; decimal items run shift-add-3
// steps of two value bits each until the step counter ends. Digits are then
// counted, sections planned and the output register filled, and one character
// transfers per handshake. The next item is accepted the cycle after the last
// character transfers. Reset clears the sequencer, step counter and output valid.
// A stalled out_ready holds the current character and pauses the emitter.
module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    input  logic        signed_value,
    input  logic [1:0]  mode,
    input  logic        left_justify,
    input  logic        force_plus,
    input  logic        space_sign,
    input  logic        zero_pad,
    input  logic        upper_case,
    input  logic        alt_prefix,
    input  logic [5:0]  field_width,
    input  logic [5:0]  min_digits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last
);
    import itaf_pkg::*;

    state_t               state_reg, state_next;
    logic                 accept;
    logic                 count_en;
    logic                 start_emit;
    logic                 neg_in;
    logic [63:0]          magnitude;
    digit_vec_t           digits;
    logic [DIG_IDX_W-1:0] num_digits;
    logic [DIG_IDX_W-1:0] ndig_reg;
    logic                 dig_done;
    logic                 emit_done;
    plan_t                plan;

    // captured conversion settings
    logic [1:0]       mode_reg;
    logic             neg_reg, left_reg, plus_reg, space_reg, zero_reg, upper_reg, alt_reg;
    logic [CNT_W-1:0] fw_reg, md_reg;

    // plan arithmetic
    logic [CNT_W-1:0] w_sat, p_sat, w_adj, ndig_w, max_len, pz, zcnt, pad;
    logic [CNT_W:0]   need;
    logic [1:0]       pre;
    logic             sgn;

    assign accept    = in_valid && in_ready;
    assign neg_in    = signed_value && (mode == MODE_DEC) && value[63];
    assign magnitude = neg_in ? (64'd0 - value) : value;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CONV;
            ST_CONV:  if (dig_done) state_next = ST_COUNT;
            ST_COUNT: state_next = ST_PLAN;
            ST_PLAN:  state_next = ST_EMIT;
            ST_EMIT:  if (emit_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        count_en   = 1'b0;
        start_emit = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready   = 1'b1;
            ST_CONV:  ;
            ST_COUNT: count_en   = 1'b1;
            ST_PLAN:  start_emit = 1'b1;
            ST_EMIT:  ;
            default:  ;
        endcase
    end

    // hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // capture settings on input transfer, digit count after conversion
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            neg_reg   <= neg_in;
            left_reg  <= left_justify;
            plus_reg  <= force_plus;
            space_reg <= space_sign;
            zero_reg  <= zero_pad;
            upper_reg <= upper_case;
            alt_reg   <= alt_prefix;
            fw_reg    <= field_width;
            md_reg    <= min_digits;
        end
        if (count_en)
        begin
            ndig_reg <= num_digits;
        end
    end

    // work out section sizes and boundaries
    always_comb
    begin
        w_sat   = (fw_reg > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : fw_reg;
        p_sat   = (md_reg > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : md_reg;
        pre     = (alt_reg && (mode_reg != MODE_DEC)) ?
                  ((mode_reg == MODE_OCT) ? 2'd1 : 2'd2) : 2'd0;
        w_adj   = (w_sat >= {4'd0, pre}) ? w_sat - {4'd0, pre} : '0;
        sgn     = neg_reg || space_reg || plus_reg;
        ndig_w  = {1'b0, ndig_reg};
        max_len = (p_sat > ndig_w) ? p_sat : ndig_w;
        need    = {1'b0, max_len} + {{CNT_W{1'b0}}, sgn};
        pad     = (!zero_reg && ({1'b0, w_adj} > need)) ?
                  CNT_W'({1'b0, w_adj} - need) : '0;
        pz      = (zero_reg && (w_adj > p_sat)) ? w_adj : p_sat;
        zcnt    = (pz > ndig_w) ? pz - ndig_w : '0;

        plan.b_pre    = {4'd0, pre};
        plan.b_sgn    = plan.b_pre + {{(CNT_W-1){1'b0}}, sgn};
        plan.b_lpad   = plan.b_sgn + (left_reg ? '0 : pad);
        plan.b_zero   = plan.b_lpad + zcnt;
        plan.b_dig    = plan.b_zero + ndig_w;
        plan.total    = plan.b_dig + (left_reg ? pad : '0);
        plan.sign_sym = neg_reg ? CH_MINUS : (space_reg ? CH_SPACE : CH_PLUS);
        plan.upper    = upper_reg;
    end

    itaf_digits u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .mode       (mode),
        .magnitude  (magnitude),
        .digits     (digits),
        .num_digits (num_digits),
        .done       (dig_done)
    );

    itaf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_emit),
        .plan      (plan),
        .digits    (digits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last),
        .done      (emit_done)
    );

    a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_EMIT)
        else $error("character offered outside emit phase");

    a_accept_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CONV)
        else $error("input transfer did not start conversion");

    a_plan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLAN) |-> plan.total != '0)
        else $error("planned item has no characters");

endmodule

// ===== sv/itaf_digits.sv =====
// Digit unit: splits the magnitude into radix digits, decimal through a shift-add-3 loop.
module itaf_digits (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [1:0]                       mode,
    input  logic [63:0]                      magnitude,
    output itaf_pkg::digit_vec_t             digits,
    output logic [itaf_pkg::DIG_IDX_W-1:0]   num_digits,
    output logic                             done
);
    import itaf_pkg::*;

    localparam int DW = NUM_DIGITS * 4;

    logic [DD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]       dig_reg, dig_next;
    logic [63:0]         bin_reg, bin_next;
    logic [DW-1:0]       dd_mid;
    logic [65:0]         oct_src;

    // one double-dabble step: adjust each BCD digit, then shift one bit in
    function automatic logic [DW-1:0] dd_shift(input logic [DW-1:0] bcd, input logic bit_in);
        logic [DW-1:0] adj;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
        end
        return {adj[DW-2:0], bit_in};
    endfunction

    assign oct_src = {2'b00, magnitude};
    assign dd_mid  = dd_shift(dig_reg, bin_reg[63]);

    // load the digit register or run two conversion bits per cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        dig_next = dig_reg;
        bin_next = bin_reg;
        if (load)
        begin
            priority if (mode == MODE_DEC)
            begin
                dig_next = '0;
                bin_next = magnitude;
                cnt_next = DD_CNT_W'(DD_STEPS);
            end
            else if (mode == MODE_OCT)
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    dig_next[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
                end
                cnt_next = '0;
            end
            else
            begin
                dig_next = '0;
                dig_next[63:0] = magnitude;
                cnt_next = '0;
            end
        end
        else if (cnt_reg != '0)
        begin
            dig_next = dd_shift(dd_mid, bin_reg[62]);
            bin_next = {bin_reg[61:0], 2'b00};
            cnt_next = cnt_reg - DD_CNT_W'(1);
        end
    end

    // hold the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // hold the digit and remaining-bit registers
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

    // find the highest nonzero digit, at least one digit
    always_comb
    begin
        num_digits = DIG_IDX_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (dig_reg[4*i +: 4] != 4'd0)
            begin
                num_digits = DIG_IDX_W'(i + 1);
            end
        end
    end

    assign digits = dig_reg;
    assign done   = (cnt_reg == '0);

    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> cnt_reg == '0)
        else $error("digit unit loaded while converting");

endmodule

// ===== sv/itaf_emit.sv =====
// Character emitter: walks the output positions and drives the registered result channel.
module itaf_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  itaf_pkg::plan_t        plan,
    input  itaf_pkg::digit_vec_t   digits,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_char,
    output logic                   last,
    output logic                   done
);
    import itaf_pkg::*;

    plan_t            plan_reg;
    logic             active_reg, active_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg;
    logic             last_reg;
    logic [CNT_W-1:0] dig_pos;
    logic [7:0]       cur_char;
    logic             cur_last;
    logic             load_out;

    assign dig_pos  = plan_reg.b_dig - CNT_W'(1) - pos_reg;
    assign cur_last = (pos_reg == plan_reg.total - CNT_W'(1));
    assign load_out = active_reg && (!out_valid_reg || out_ready);

    // pick the character of the current position by section
    always_comb
    begin
        priority if (pos_reg < plan_reg.b_pre)
        begin
            cur_char = (pos_reg == '0) ? CH_ZERO : (plan_reg.upper ? CH_X_UP : CH_X_LO);
        end
        else if (pos_reg < plan_reg.b_sgn)
        begin
            cur_char = plan_reg.sign_sym;
        end
        else if (pos_reg < plan_reg.b_lpad)
        begin
            cur_char = CH_SPACE;
        end
        else if (pos_reg < plan_reg.b_zero)
        begin
            cur_char = CH_ZERO;
        end
        else if (pos_reg < plan_reg.b_dig)
        begin
            cur_char = digit_char(digits[dig_pos[DIG_IDX_W-1:0]], plan_reg.upper);
        end
        else
        begin
            cur_char = CH_SPACE;
        end
    end

    // advance position and output valid
    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (start)
        begin
            active_next = 1'b1;
            pos_next    = '0;
        end
        else if (load_out)
        begin
            out_valid_next = 1'b1;
            pos_next       = pos_reg + CNT_W'(1);
            if (cur_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold plan and output payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            plan_reg <= plan;
        end
        if (load_out && !start)
        begin
            out_char_reg <= cur_char;
            last_reg     <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign done      = out_valid_reg && out_ready && last_reg;

    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !active_reg && !out_valid_reg)
        else $error("emitter started while busy");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> pos_reg < plan_reg.total)
        else $error("emitter position past end of item");

endmodule
